@@ rtl/ssimwms_pkg.sv @@
package ssimwms_pkg;

	// Default sample width of x and y
	localparam int SAMPLE_WIDTH_DEF = 16;

	// Window geometry
	localparam int SMALL_SIDE = 4;
	localparam int LARGE_SIDE = 8;
	localparam int SMALL_LEN  = SMALL_SIDE * SMALL_SIDE;
	localparam int LARGE_LEN  = LARGE_SIDE * LARGE_SIDE;
	localparam int COUNT_W    = 6;

	// Accumulator and result field widths
	localparam int ACC_LIN_W = 23;
	localparam int SUM_W     = 22;
	localparam int SQ_W      = 37;
	localparam int CROSS_W   = 38;

	// Result word packing
	localparam int OUT_W       = 2 * SUM_W + 2 * SQ_W + CROSS_W;
	localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_BYTES_W - OUT_W;

	typedef enum logic {
		WIN_4X4 = 1'b0,
		WIN_8X8 = 1'b1
	} win_mode_t;

	// Occupancy of one pipeline stage
	typedef struct packed {
		logic valid;
		logic last;
	} stage_ctl_t;

endpackage

@@ rtl/ssimwms_input_stage.sv @@
module ssimwms_input_stage #(
	parameter int SAMPLE_WIDTH = ssimwms_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] x_in,
	input  logic signed [SAMPLE_WIDTH-1:0] y_in,
	input  ssimwms_pkg::win_mode_t         window_mode,
	input  logic                           adv_s1,
	output ssimwms_pkg::stage_ctl_t        ctl_s1,
	output logic signed [SAMPLE_WIDTH-1:0] x_s1,
	output logic signed [SAMPLE_WIDTH-1:0] y_s1
);

	localparam int CW = ssimwms_pkg::COUNT_W;

	logic [CW-1:0] count_q;
	logic [CW:0]   count_inc;
	logic [CW:0]   win_len;
	logic          is_last;
	logic          take;

	assign in_ready  = !ctl_s1.valid || adv_s1;
	assign take      = in_ready && in_valid;
	assign count_inc = {1'b0, count_q} + (CW+1)'(1);
	assign win_len   = (window_mode == ssimwms_pkg::WIN_8X8) ?
			(CW+1)'(ssimwms_pkg::LARGE_LEN) : (CW+1)'(ssimwms_pkg::SMALL_LEN);
	// Close the window once the count reaches its length, even past it
	assign is_last   = (count_inc >= win_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			count_q <= '0;
		end else if (in_ready) begin
			ctl_s1.valid <= in_valid;
			if (in_valid) begin
				ctl_s1.last <= is_last;
				count_q     <= is_last ? '0 : count_inc[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_s1 <= x_in;
			y_s1 <= y_in;
		end
	end

endmodule

@@ rtl/ssimwms_product_stage.sv @@
module ssimwms_product_stage #(
	parameter int SAMPLE_WIDTH = ssimwms_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ssimwms_pkg::stage_ctl_t          ctl_s1,
	input  logic signed [SAMPLE_WIDTH-1:0]   x_s1,
	input  logic signed [SAMPLE_WIDTH-1:0]   y_s1,
	output logic                             adv_s1,
	input  logic                             adv_s2,
	output ssimwms_pkg::stage_ctl_t          ctl_s2,
	output logic signed [SAMPLE_WIDTH-1:0]   x_s2,
	output logic signed [SAMPLE_WIDTH-1:0]   y_s2,
	output logic signed [2*SAMPLE_WIDTH-1:0] xx_s2,
	output logic signed [2*SAMPLE_WIDTH-1:0] yy_s2,
	output logic signed [2*SAMPLE_WIDTH-1:0] xy_s2
);

	logic load;

	assign adv_s1 = !ctl_s2.valid || adv_s2;
	assign load   = adv_s1 && ctl_s1.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv_s1) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Three independent multiplies, registered before accumulation
	always_ff @(posedge clk) begin
		if (load) begin
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			xx_s2 <= x_s1 * x_s1;
			yy_s2 <= y_s1 * y_s1;
			xy_s2 <= x_s1 * y_s1;
		end
	end

endmodule

@@ rtl/ssimwms_accumulator.sv @@
module ssimwms_accumulator #(
	parameter int SAMPLE_WIDTH = ssimwms_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  ssimwms_pkg::stage_ctl_t                 ctl_s2,
	input  logic signed [SAMPLE_WIDTH-1:0]          x_s2,
	input  logic signed [SAMPLE_WIDTH-1:0]          y_s2,
	input  logic signed [2*SAMPLE_WIDTH-1:0]        xx_s2,
	input  logic signed [2*SAMPLE_WIDTH-1:0]        yy_s2,
	input  logic signed [2*SAMPLE_WIDTH-1:0]        xy_s2,
	output logic                                    adv_s2,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [ssimwms_pkg::SUM_W-1:0]           sum_x,
	output logic [ssimwms_pkg::SQ_W-1:0]            sum_x_squared,
	output logic [ssimwms_pkg::SUM_W-1:0]           sum_y,
	output logic [ssimwms_pkg::SQ_W-1:0]            sum_y_squared,
	output logic [ssimwms_pkg::CROSS_W-1:0]         sum_cross
);

	localparam int LW    = ssimwms_pkg::ACC_LIN_W;
	localparam int QW    = ssimwms_pkg::SQ_W;
	localparam int XW    = ssimwms_pkg::CROSS_W;
	localparam int PW    = 2 * SAMPLE_WIDTH;
	localparam int LIN_E = (SAMPLE_WIDTH > LW) ? SAMPLE_WIDTH : LW;
	localparam int PRD_E = (PW > XW) ? PW : XW;

	logic [LW-1:0] acc_x_q, acc_y_q;
	logic [QW-1:0] acc_xx_q, acc_yy_q;
	logic [XW-1:0] acc_xy_q;

	logic signed [LIN_E-1:0] x_ext, y_ext;
	logic signed [PRD_E-1:0] xx_ext, yy_ext, xy_ext;

	logic [LW-1:0] nxt_x, nxt_y;
	logic [QW-1:0] nxt_xx, nxt_yy;
	logic [XW-1:0] nxt_xy;

	logic out_free;
	logic consume;
	logic close;

	assign out_free = !out_valid || out_ready;
	// Hold a closing word in stage 2 while the result register is full and not read
	assign adv_s2   = !ctl_s2.valid || !ctl_s2.last || out_free;
	assign consume  = ctl_s2.valid && adv_s2;
	assign close    = consume && ctl_s2.last;

	assign x_ext  = LIN_E'(x_s2);
	assign y_ext  = LIN_E'(y_s2);
	assign xx_ext = PRD_E'(xx_s2);
	assign yy_ext = PRD_E'(yy_s2);
	assign xy_ext = PRD_E'(xy_s2);

	assign nxt_x  = acc_x_q  + x_ext[LW-1:0];
	assign nxt_y  = acc_y_q  + y_ext[LW-1:0];
	assign nxt_xx = acc_xx_q + xx_ext[QW-1:0];
	assign nxt_yy = acc_yy_q + yy_ext[QW-1:0];
	assign nxt_xy = acc_xy_q + xy_ext[XW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			acc_x_q   <= '0;
			acc_y_q   <= '0;
			acc_xx_q  <= '0;
			acc_yy_q  <= '0;
			acc_xy_q  <= '0;
		end else begin
			if (close) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (consume) begin
				acc_x_q  <= close ? '0 : nxt_x;
				acc_y_q  <= close ? '0 : nxt_y;
				acc_xx_q <= close ? '0 : nxt_xx;
				acc_yy_q <= close ? '0 : nxt_yy;
				acc_xy_q <= close ? '0 : nxt_xy;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (close) begin
			sum_x         <= nxt_x[ssimwms_pkg::SUM_W-1:0];
			sum_x_squared <= nxt_xx;
			sum_y         <= nxt_y[ssimwms_pkg::SUM_W-1:0];
			sum_y_squared <= nxt_yy;
			sum_cross     <= nxt_xy;
		end
	end

endmodule

@@ rtl/ssim_window_moment_sums_unit.sv @@
// Window moment sums for SSIM. Each input word carries one pixel pair (x, y)
// of a square window, in row order; the window is 4x4 (16 pairs) or 8x8
// (64 pairs) as set by bit 0 of the configuration register (reset: 4x4).
// On the last pair of a window the block emits one result word with the
// exact sums of x, x*x, y, y*y and x*y, then starts the next window from
// zero. A new pair is taken every cycle while input is not held off: the
// pipeline is an input register, a product register (three multipliers of
// SAMPLE_WIDTH by SAMPLE_WIDTH bits) and the accumulators that feed a one-deep
// result register, loaded as the closing pair leaves the product register.
// Input is held off only when a second window closes while the previous
// result has not yet been taken. Write the window size only while no pair is
// in the pipeline; a change in the middle of a window keeps the partial sums,
// and if the count already stands at 16 or more when 4x4 is chosen, the next
// pair closes the window. Sums that exceed their field widths wrap.
module ssim_window_moment_sums_unit #(
	parameter int SAMPLE_WIDTH = ssimwms_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration: bit 0 = window_mode
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [0:0]                          cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// x_sample, y_sample, zero padding
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// sum_x, sum_x_squared, sum_y, sum_y_squared, sum_cross, zero padding
	output logic [ssimwms_pkg::OUT_BYTES_W-1:0] m_axis_tdata
);

	localparam int SW = SAMPLE_WIDTH;

	ssimwms_pkg::win_mode_t  mode_q;
	ssimwms_pkg::stage_ctl_t ctl_s1, ctl_s2;

	logic signed [SW-1:0]   x_s1, y_s1, x_s2, y_s2;
	logic signed [2*SW-1:0] xx_s2, yy_s2, xy_s2;
	logic                   adv_s1, adv_s2;

	logic [ssimwms_pkg::SUM_W-1:0]   sum_x, sum_y;
	logic [ssimwms_pkg::SQ_W-1:0]    sum_x_squared, sum_y_squared;
	logic [ssimwms_pkg::CROSS_W-1:0] sum_cross;

	// Configuration write is always taken at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ssimwms_pkg::WIN_4X4;
		end else if (cfg_valid) begin
			mode_q <= ssimwms_pkg::win_mode_t'(cfg_data[0]);
		end
	end

	// Register the pair and track the position inside the window
	ssimwms_input_stage #(.SAMPLE_WIDTH(SW)) u_input (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.x_in       (s_axis_tdata[SW-1:0]),
		.y_in       (s_axis_tdata[2*SW-1:SW]),
		.window_mode(mode_q),
		.adv_s1     (adv_s1),
		.ctl_s1     (ctl_s1),
		.x_s1       (x_s1),
		.y_s1       (y_s1)
	);

	// Form the squares and the cross product
	ssimwms_product_stage #(.SAMPLE_WIDTH(SW)) u_product (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl_s1(ctl_s1),
		.x_s1  (x_s1),
		.y_s1  (y_s1),
		.adv_s1(adv_s1),
		.adv_s2(adv_s2),
		.ctl_s2(ctl_s2),
		.x_s2  (x_s2),
		.y_s2  (y_s2),
		.xx_s2 (xx_s2),
		.yy_s2 (yy_s2),
		.xy_s2 (xy_s2)
	);

	// Accumulate and hand the closed window to the result register
	ssimwms_accumulator #(.SAMPLE_WIDTH(SW)) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s2       (ctl_s2),
		.x_s2         (x_s2),
		.y_s2         (y_s2),
		.xx_s2        (xx_s2),
		.yy_s2        (yy_s2),
		.xy_s2        (xy_s2),
		.adv_s2       (adv_s2),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.sum_x        (sum_x),
		.sum_x_squared(sum_x_squared),
		.sum_y        (sum_y),
		.sum_y_squared(sum_y_squared),
		.sum_cross    (sum_cross)
	);

	assign m_axis_tdata = {{ssimwms_pkg::OUT_PAD_W{1'b0}}, sum_cross, sum_y_squared,
			sum_y, sum_x_squared, sum_x};

`ifndef ASSERT_OFF
	// An empty result register never holds off input
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty result register");

	// Input is held off only behind a result that waits
	a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && ctl_s2.valid && ctl_s2.last))
		else $error("input stalled without a blocked closing word");

	// A new result comes only from a closing word in stage 2
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(ctl_s2.valid && ctl_s2.last))
		else $error("result without a window close");
`endif

endmodule
